### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the pan fusion RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define BMPF_ASSERT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define BMPF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bmpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpf_pkg
// Widths, mode codes and beat types of the pan fusion pipeline.
// ----------------------------------------------------------------------------
package bmpf_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int LANES       = 3;
    localparam int SUM_BITS    = SAMPLE_BITS + 2;
    localparam int PROD_BITS   = 2 * SAMPLE_BITS;
    // 2*band*pan + sum
    localparam int NUM_BITS    = PROD_BITS + 2;
    // 2*sum, and also holds the divisor 2^SAMPLE_BITS of the product mode
    localparam int DEN_BITS    = SAMPLE_BITS + 3;

    localparam logic MODE_BROVEY = 1'b0;
    localparam logic MODE_MULT   = 1'b1;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t pan_sample;
        sample_t band_one;
        sample_t band_two;
        sample_t band_three;
    } pixel_t;

    typedef struct packed {
        sample_t fused_one;
        sample_t fused_two;
        sample_t fused_three;
        logic    zero_sum;
    } fused_t;

    typedef struct packed {
        logic                               mode;
        logic [LANES-1:0][PROD_BITS-1:0]    prod;
        logic [SUM_BITS-1:0]                sum;
    } prod_beat_t;

    typedef struct packed {
        logic                               zero;
        logic [DEN_BITS-1:0]                den;
        logic [LANES-1:0][DEN_BITS-1:0]     rem;
        logic [LANES-1:0][SAMPLE_BITS-1:0]  low;
        logic [LANES-1:0][SAMPLE_BITS-1:0]  quo;
    } div_beat_t;

endpackage

### hdl/bmpf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpf_front
// Two register stages: band products and band sum, then dividend and
// divisor set-up for the shared quotient pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmpf_front
    import bmpf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      mode,
    input  logic      in_valid,
    output logic      in_ready,
    input  pixel_t    in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output div_beat_t out_data
);

    logic       prod_valid_reg;
    prod_beat_t prod_reg;
    prod_beat_t prod_next;
    logic       div_valid_reg;
    div_beat_t  div_reg;
    div_beat_t  div_next;
    logic       stage1_ready;
    logic       stage2_ready;

    logic [LANES-1:0][SAMPLE_BITS-1:0] band;
    logic [LANES-1:0][NUM_BITS-1:0]    num;

    assign stage2_ready = !div_valid_reg || out_ready;
    assign stage1_ready = !prod_valid_reg || stage2_ready;
    assign in_ready     = stage1_ready;
    assign out_valid    = div_valid_reg;
    assign out_data     = div_reg;

    // products of pan with each band, and the band sum
    always_comb begin
        band[0] = in_data.band_one;
        band[1] = in_data.band_two;
        band[2] = in_data.band_three;
        prod_next.mode = mode;
        for (int k = 0; k < LANES; k++) begin
            prod_next.prod[k] = PROD_BITS'(in_data.pan_sample) * PROD_BITS'(band[k]);
        end
        prod_next.sum = SUM_BITS'(in_data.band_one) + SUM_BITS'(in_data.band_two)
                      + SUM_BITS'(in_data.band_three);
    end

    // dividend and divisor; the product mode divides by 2^SAMPLE_BITS
    always_comb begin
        div_next.zero = (prod_reg.mode == MODE_BROVEY) && (prod_reg.sum == '0);
        if (prod_reg.mode == MODE_MULT) begin
            div_next.den = DEN_BITS'(1) << SAMPLE_BITS;
        end else begin
            div_next.den = DEN_BITS'({prod_reg.sum, 1'b0});
        end
        for (int k = 0; k < LANES; k++) begin
            if (prod_reg.mode == MODE_MULT) begin
                num[k] = NUM_BITS'(prod_reg.prod[k]);
            end else begin
                num[k] = NUM_BITS'({prod_reg.prod[k], 1'b0}) + NUM_BITS'(prod_reg.sum);
            end
            div_next.rem[k] = DEN_BITS'(num[k][NUM_BITS-1:SAMPLE_BITS]);
            div_next.low[k] = num[k][SAMPLE_BITS-1:0];
            div_next.quo[k] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            div_valid_reg  <= 1'b0;
        end else begin
            if (stage1_ready) begin
                prod_valid_reg <= in_valid;
            end
            if (stage2_ready) begin
                div_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && stage1_ready) begin
            prod_reg <= prod_next;
        end
        if (prod_valid_reg && stage2_ready) begin
            div_reg <= div_next;
        end
    end

    `BMPF_ASSERT_NEXT(a_accept_lands, aclk, aresetn, in_valid && in_ready, prod_valid_reg, "accepted pixel missing from product stage")
    `BMPF_ASSERT(a_den_nonzero, aclk, aresetn, div_valid_reg && !div_reg.zero, div_reg.den != '0, "zero divisor without zero flag")

endmodule

### hdl/bmpf_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpf_div_step
// One restoring division step for all three lanes: one quotient bit per
// stage, shared divisor.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmpf_div_step
    import bmpf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  div_beat_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output div_beat_t out_data
);

    logic      valid_reg;
    div_beat_t data_reg;
    div_beat_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // shift in the next dividend bit, subtract the divisor where it fits
    always_comb begin
        logic [DEN_BITS:0] trial;
        logic              take;
        data_next = in_data;
        for (int k = 0; k < LANES; k++) begin
            trial = {in_data.rem[k], in_data.low[k][SAMPLE_BITS-1]};
            take  = trial >= {1'b0, in_data.den};
            if (take) begin
                data_next.rem[k] = DEN_BITS'(trial - {1'b0, in_data.den});
            end else begin
                data_next.rem[k] = DEN_BITS'(trial);
            end
            data_next.low[k] = {in_data.low[k][SAMPLE_BITS-2:0], 1'b0};
            data_next.quo[k] = {in_data.quo[k][SAMPLE_BITS-2:0], take};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    `BMPF_ASSERT(a_rem_below_den, aclk, aresetn, valid_reg && !data_reg.zero, (data_reg.rem[0] < data_reg.den) && (data_reg.rem[1] < data_reg.den) && (data_reg.rem[2] < data_reg.den), "partial remainder not below divisor")

endmodule

### hdl/brovey_multiplicative_pan_fusion_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brovey_multiplicative_pan_fusion_core
// Pan sharpening of one pixel per clock while m_ready does not stall: Brovey ratio or multiplicative
// fusion of three multispectral bands with a panchromatic sample.
// ----------------------------------------------------------------------------
//
//   channel  ports                        beat
//   -------  ---------------------------  -------------------------------------
//   input    s_valid, s_ready, s_data     pixel_t: pan and three band samples
//   result   m_valid, m_ready, m_data     fused_t: three fused bands, zero flag
//   config   cfg_wr_en, cfg_wr_data       fusion mode, 0 Brovey, 1 multiplicative
//
// Throughput is one beat per clock while m_ready does not stall. Each beat
// passes a product stage, a dividend set-up stage, one stage per quotient
// bit of the restoring divider, and the output register.
// Reset is synchronous, active low; it clears all valid bits and selects
// Brovey mode. A stall at m_ready holds beats in place; empty stages still
// fill, so s_ready drops only when every stage is occupied.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brovey_multiplicative_pan_fusion_core
    import bmpf_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   cfg_wr_en,
    input  logic   cfg_wr_data,
    input  logic   s_valid,
    output logic   s_ready,
    input  pixel_t s_data,
    output logic   m_valid,
    input  logic   m_ready,
    output fused_t m_data
);

    // Fusion mode; it is captured with each pixel in the product stage.
    logic fusion_mode_reg;

    // Divider chain: index 0 is fed by the front end, the last index feeds
    // the output register.
    logic      [SAMPLE_BITS:0] div_valid;
    logic      [SAMPLE_BITS:0] div_ready;
    div_beat_t                 div_data [SAMPLE_BITS+1];

    div_beat_t last_beat;
    logic      m_valid_reg;
    fused_t    m_data_reg;
    fused_t    m_data_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fusion_mode_reg <= MODE_BROVEY;
        end else if (cfg_wr_en) begin
            fusion_mode_reg <= cfg_wr_data;
        end
    end

    // Products, band sum, dividend and divisor.
    bmpf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mode      (fusion_mode_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    // One quotient bit per stage, most significant first.
    for (genvar s = 0; s < SAMPLE_BITS; s++) begin : g_div
        bmpf_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (div_valid[s]),
            .in_ready  (div_ready[s]),
            .in_data   (div_data[s]),
            .out_valid (div_valid[s+1]),
            .out_ready (div_ready[s+1]),
            .out_data  (div_data[s+1])
        );
    end

    // Output register: advance when empty or when the sink takes the beat.
    assign div_ready[SAMPLE_BITS] = !m_valid_reg || m_ready;
    assign last_beat              = div_data[SAMPLE_BITS];

    // Force zero results when Brovey mode met three zero bands.
    always_comb begin
        m_data_next.zero_sum = last_beat.zero;
        if (last_beat.zero) begin
            m_data_next.fused_one   = '0;
            m_data_next.fused_two   = '0;
            m_data_next.fused_three = '0;
        end else begin
            m_data_next.fused_one   = last_beat.quo[0];
            m_data_next.fused_two   = last_beat.quo[1];
            m_data_next.fused_three = last_beat.quo[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (div_ready[SAMPLE_BITS]) begin
            m_valid_reg <= div_valid[SAMPLE_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (div_valid[SAMPLE_BITS] && div_ready[SAMPLE_BITS]) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `BMPF_ASSERT(a_zero_flag_clears, aclk, aresetn, m_valid && m_data.zero_sum, (m_data.fused_one == '0) && (m_data.fused_two == '0) && (m_data.fused_three == '0), "zero flag with nonzero fused samples")
    `BMPF_ASSERT(a_backpressure_full, aclk, aresetn, !s_ready, m_valid && !m_ready, "input held off while output side can move")

endmodule

### sim/tb_brovey_multiplicative_pan_fusion_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_brovey_multiplicative_pan_fusion_core
// Self-checking bench for the Brovey / multiplicative pan fusion core.
// A queue-fed driver sends pixels and a monitor checks every fused beat
// against a behavioral predictor. The run covers a directed set in both
// modes, then random phases with random sender and receiver idling. The
// fusion mode is changed only between phases, once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_brovey_multiplicative_pan_fusion_core;
    import bmpf_pkg::*;

    localparam int  CLK_HALF_NS   = 4;
    localparam int  PIPE_LATENCY  = SAMPLE_BITS + 3;
    localparam int  RANDOM_PIXELS = 2000;
    localparam time RUN_LIMIT_NS  = 2_000_000;
    localparam int  SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;

    logic   aclk        = 1'b0;
    logic   aresetn     = 1'b0;
    logic   cfg_wr_en   = 1'b0;
    logic   cfg_wr_data = MODE_BROVEY;
    logic   s_valid     = 1'b0;
    logic   s_ready;
    pixel_t s_data      = '0;
    logic   m_valid;
    logic   m_ready     = 1'b0;
    fused_t m_data;

    // Pixels waiting to be sent and fused beats waiting to come back.
    pixel_t pixel_pending [$];
    fused_t fused_expected [$];

    // Mode the block holds, as last written over the config port.
    logic mode_shadow = MODE_BROVEY;
    // Set for the final phase: no idling on either side.
    bit   calm        = 1'b0;

    int   gap_left    = 0;
    int   stall_left  = 0;
    int   mismatches  = 0;
    int   brovey_beats = 0;
    int   mult_beats   = 0;
    int   zero_flags   = 0;
    int   beats_checked = 0;
    int   mode_writes   = 0;

    brovey_multiplicative_pan_fusion_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always begin
        #CLK_HALF_NS aclk = 1'b1;
        #CLK_HALF_NS aclk = 1'b0;
    end

    // Fuse one pixel the way the block should, in the given mode.
    function automatic fused_t fuse_pixel(pixel_t px, logic mode);
        fused_t      f;
        int unsigned total;
        int unsigned lane [3];
        int unsigned fz   [3];
        lane[0] = px.band_one;
        lane[1] = px.band_two;
        lane[2] = px.band_three;
        total   = lane[0] + lane[1] + lane[2];
        for (int k = 0; k < 3; k++) begin
            if (mode == MODE_BROVEY) begin
                // Round to nearest, halves up: floor((2*b*p + s) / (2*s)).
                if (total == 0) begin
                    fz[k] = 0;
                end else begin
                    fz[k] = (2 * lane[k] * px.pan_sample + total) / (2 * total);
                end
            end else begin
                fz[k] = (px.pan_sample * lane[k]) >> SAMPLE_BITS;
            end
        end
        f.fused_one   = sample_t'(fz[0]);
        f.fused_two   = sample_t'(fz[1]);
        f.fused_three = sample_t'(fz[2]);
        f.zero_sum    = (mode == MODE_BROVEY) && (total == 0);
        return f;
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return sample_t'(SAMPLE_MAX);
            2:       return sample_t'($urandom_range(0, 3));
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic queue_pixel(int pan, int b1, int b2, int b3);
        pixel_t px;
        px.pan_sample = sample_t'(pan);
        px.band_one   = sample_t'(b1);
        px.band_two   = sample_t'(b2);
        px.band_three = sample_t'(b3);
        pixel_pending.push_back(px);
    endtask

    task automatic queue_random_pixel();
        pixel_t px;
        px.pan_sample = pick_sample();
        px.band_one   = pick_sample();
        px.band_two   = pick_sample();
        px.band_three = pick_sample();
        // Now and then force a dark pixel to hit the zero-sum path.
        if ($urandom_range(0, 11) == 0) begin
            px.band_one   = '0;
            px.band_two   = '0;
            px.band_three = '0;
        end
        pixel_pending.push_back(px);
    endtask

    // Hold until the sender is empty and every fused beat has come back.
    task automatic wait_drained();
        while (pixel_pending.size() != 0 || s_valid || fused_expected.size() != 0)
            @(posedge aclk);
    endtask

    // Write the mode register; only called with the pipeline drained.
    task automatic write_mode(logic mode);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        mode_shadow = mode;
        mode_writes++;
    endtask

    task automatic queue_directed();
        queue_pixel(0, 0, 0, 0);                        // dark pixel
        queue_pixel(SAMPLE_MAX, 0, 0, 0);               // bright pan, no bands
        queue_pixel(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        queue_pixel(0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        queue_pixel(SAMPLE_MAX, SAMPLE_MAX, 0, 0);      // one band carries all
        queue_pixel(SAMPLE_MAX, 0, 0, 1);
        queue_pixel(1, 1, 1, 0);                        // exact half rounds up
        queue_pixel(3, 1, 1, 1);
        queue_pixel(5, 1, 1, 2);                        // quarter-step ratios
        queue_pixel(170, 85, 85, 85);
        queue_pixel(128, 128, 64, 32);
    endtask

    // Driver: advance to the next pending pixel whenever the current beat
    // is taken or the line is empty; insert short gaps at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                fused_expected.push_back(fuse_pixel(s_data, mode_shadow));
                if (mode_shadow == MODE_BROVEY) brovey_beats++;
                else mult_beats++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pixel_pending.size() != 0) begin
                    s_data  <= pixel_pending.pop_front();
                    s_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(1, 4);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each fused beat against the oldest expectation and
    // drop m_ready in random bursts to back-pressure the pipeline.
    always @(posedge aclk) begin
        fused_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (fused_expected.size() == 0) begin
                    $display("%0t: unexpected fused beat %h", $time, m_data);
                    mismatches++;
                end else begin
                    want = fused_expected.pop_front();
                    beats_checked++;
                    if (want.zero_sum) zero_flags++;
                    if (m_data.fused_one !== want.fused_one) begin
                        $display("%0t: fused_one expected %0d, actual %0d",
                                 $time, want.fused_one, m_data.fused_one);
                        mismatches++;
                    end
                    if (m_data.fused_two !== want.fused_two) begin
                        $display("%0t: fused_two expected %0d, actual %0d",
                                 $time, want.fused_two, m_data.fused_two);
                        mismatches++;
                    end
                    if (m_data.fused_three !== want.fused_three) begin
                        $display("%0t: fused_three expected %0d, actual %0d",
                                 $time, want.fused_three, m_data.fused_three);
                        mismatches++;
                    end
                    if (m_data.zero_sum !== want.zero_sum) begin
                        $display("%0t: zero_sum expected %0b, actual %0b",
                                 $time, want.zero_sum, m_data.zero_sum);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 6) == 0)
                    stall_left = $urandom_range(1, 4);
            end
        end
    end

    // Sequencer: reset, directed set in both modes, then random phases.
    initial begin
        int  random_left;
        int  phase_len;
        logic phase_mode;
        random_left = RANDOM_PIXELS;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        write_mode(MODE_BROVEY);
        queue_directed();
        wait_drained();

        write_mode(MODE_MULT);
        queue_directed();
        wait_drained();

        while (random_left > 0) begin
            phase_len = $urandom_range(100, 400);
            if (phase_len > random_left) phase_len = random_left;
            phase_mode = $urandom_range(0, 1) ? MODE_MULT : MODE_BROVEY;
            // Final phase runs back to back with no idling.
            if (random_left - phase_len == 0) calm = 1'b1;
            write_mode(phase_mode);
            repeat (phase_len) queue_random_pixel();
            random_left -= phase_len;
            // Pause the sender until every fused beat is back.
            wait_drained();
        end

        repeat (2 * PIPE_LATENCY) @(posedge aclk);

        $display("Covered %0d Brovey and %0d multiplicative pixels over %0d mode writes,",
                 brovey_beats, mult_beats, mode_writes);
        $display("%0d fused beats checked, %0d with the zero-sum flag.",
                 beats_checked, zero_flags);
        if (mismatches == 0 && fused_expected.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("Timeout with %0d fused beats outstanding", fused_expected.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/bmpf_pkg.sv
hdl/bmpf_front.sv
hdl/bmpf_div_step.sv
hdl/brovey_multiplicative_pan_fusion_core.sv
sim/tb_brovey_multiplicative_pan_fusion_core.sv
